[rtl/gbpe_pkg.sv]
// shared types and constants of the glyph bitmap pixel expander
package gbpe_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COLOR_W  = 16;
  localparam int unsigned WIDTH_W  = 5;
  localparam int unsigned ROWS_W   = 6;
  localparam int unsigned SCALE_W  = 2;
  localparam int unsigned BITCNT_W = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PEN_COLOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_ROWS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;

  // register reset values
  localparam logic [COLOR_W-1:0] PEN_COLOR_RST  = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_COLOR_RST   = 16'h0000;
  localparam logic [WIDTH_W-1:0] GLYPH_W_RST    = 5'd8;
  localparam logic [ROWS_W-1:0]  GLYPH_ROWS_RST = 6'd8;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 2'd1;

  // parameter defaults
  localparam int unsigned MAX_GLYPH_WIDTH_DEF = 24;
  localparam int unsigned MAX_SCALE_DEF       = 2;
  localparam int unsigned MAX_GLYPH_ROWS_DEF  = 32;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit;
  } gbpe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic final_pix;
  } gbpe_sts_t;

endpackage

[rtl/gbpe_ctrl.sv]
// controller state machine of the glyph bitmap pixel expander
module gbpe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gbpe_pkg::gbpe_sts_t sts_i,
  output gbpe_pkg::gbpe_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_pix) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/gbpe_dpath.sv]
// datapath: config registers, row store, bit shifter, repeat counters, output register
module gbpe_dpath #(
  parameter int unsigned MAX_GLYPH_WIDTH = gbpe_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned MAX_SCALE       = gbpe_pkg::MAX_SCALE_DEF,
  parameter int unsigned MAX_GLYPH_ROWS  = gbpe_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gbpe_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gbpe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [gbpe_pkg::BYTE_W-1:0]       bitmap_byte_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [gbpe_pkg::COLOR_W-1:0]      pixel_color_o,
  output logic                              last_of_glyph_o,
  input  gbpe_pkg::gbpe_cmd_t               cmd_i,
  output gbpe_pkg::gbpe_sts_t               sts_o
);

  localparam int unsigned STORE_DEPTH = (MAX_GLYPH_WIDTH + 7) / 8;
  localparam int unsigned IDX_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned NB_W   = $clog2(STORE_DEPTH + 1);
  localparam int unsigned RC_W   = $clog2(MAX_GLYPH_ROWS);
  localparam int unsigned RW_W   = $clog2(MAX_GLYPH_ROWS + 1);
  localparam int unsigned SC_W   = $clog2(MAX_SCALE + 1);
  localparam int unsigned REP_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  // pixels supplied by byte j of a row of width w
  function automatic logic [gbpe_pkg::BITCNT_W-1:0] bits_of_byte(
    input logic [gbpe_pkg::WIDTH_W-1:0] w,
    input logic [IDX_W-1:0]             j
  );
    logic [7:0] wx;
    logic [7:0] ux;
    logic [7:0] left;
    wx   = 8'(w);
    ux   = 8'({j, 3'b000});
    left = wx - ux;
    if (ux >= wx) begin
      bits_of_byte = '0;
    end else if (left >= 8'd8) begin
      bits_of_byte = gbpe_pkg::BITCNT_W'(8);
    end else begin
      bits_of_byte = gbpe_pkg::BITCNT_W'(left);
    end
  endfunction

  // configuration registers
  logic [gbpe_pkg::COLOR_W-1:0] pen_color_q, bg_color_q;
  logic [gbpe_pkg::WIDTH_W-1:0] glyph_width_q;
  logic [gbpe_pkg::ROWS_W-1:0]  glyph_rows_q;
  logic [gbpe_pkg::SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_color_q   <= gbpe_pkg::PEN_COLOR_RST;
      bg_color_q    <= gbpe_pkg::BG_COLOR_RST;
      glyph_width_q <= gbpe_pkg::GLYPH_W_RST;
      glyph_rows_q  <= gbpe_pkg::GLYPH_ROWS_RST;
      scale_q       <= gbpe_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbpe_pkg::CFG_PEN_COLOR:  pen_color_q   <= cfg_data_i;
        gbpe_pkg::CFG_BG_COLOR:   bg_color_q    <= cfg_data_i;
        gbpe_pkg::CFG_GLYPH_W:    glyph_width_q <= cfg_data_i[gbpe_pkg::WIDTH_W-1:0];
        gbpe_pkg::CFG_GLYPH_ROWS: glyph_rows_q  <= cfg_data_i[gbpe_pkg::ROWS_W-1:0];
        gbpe_pkg::CFG_SCALE:      scale_q       <= cfg_data_i[gbpe_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped settings
  logic [gbpe_pkg::WIDTH_W-1:0] width_eff;
  logic [RW_W-1:0]              rows_eff;
  logic [SC_W-1:0]              sc_eff;
  logic [NB_W-1:0]              nbytes;
  logic [IDX_W-1:0]             last_j;
  logic [REP_W-1:0]             rep_max;
  logic [NB_W-1:0]              width_bytes;

  always_comb begin
    if (glyph_width_q == '0) begin
      width_eff = gbpe_pkg::WIDTH_W'(1);
    end else if (glyph_width_q > gbpe_pkg::WIDTH_W'(MAX_GLYPH_WIDTH)) begin
      width_eff = gbpe_pkg::WIDTH_W'(MAX_GLYPH_WIDTH);
    end else begin
      width_eff = glyph_width_q;
    end

    if (glyph_rows_q == '0) begin
      rows_eff = RW_W'(1);
    end else if (glyph_rows_q > gbpe_pkg::ROWS_W'(MAX_GLYPH_ROWS)) begin
      rows_eff = RW_W'(MAX_GLYPH_ROWS);
    end else begin
      rows_eff = RW_W'(glyph_rows_q);
    end

    if (scale_q == '0) begin
      sc_eff = SC_W'(1);
    end else if (scale_q > gbpe_pkg::SCALE_W'(MAX_SCALE)) begin
      sc_eff = SC_W'(MAX_SCALE);
    end else begin
      sc_eff = SC_W'(scale_q);
    end

    width_bytes = NB_W'((6'(width_eff) + 6'd7) >> 3);
    nbytes      = (width_bytes > NB_W'(STORE_DEPTH)) ? NB_W'(STORE_DEPTH) : width_bytes;
    last_j      = IDX_W'(nbytes - NB_W'(1));
    rep_max     = REP_W'(sc_eff - SC_W'(1));
  end

  // row and glyph position
  logic [gbpe_pkg::BYTE_W-1:0] store_q [STORE_DEPTH];
  logic [IDX_W-1:0]            byte_in_row_q;
  logic [RC_W-1:0]             row_count_q;

  // emission state of the current word
  logic [gbpe_pkg::BYTE_W-1:0]   sh_q;
  logic [gbpe_pkg::BITCNT_W-1:0] bits_q;
  logic [REP_W-1:0]              rep_q;
  logic [REP_W-1:0]              pass_q;
  logic [IDX_W-1:0]              j_q;
  logic                          end_row_q;
  logic                          glyph_end_q;

  // output register
  logic                          out_valid_q;
  logic [gbpe_pkg::COLOR_W-1:0]  pixel_q;
  logic                          last_q;

  logic [IDX_W-1:0] idx;
  logic             end_row;
  logic [RW_W-1:0]  rc_inc;
  logic             glyph_end;
  logic             rep_last, bit_last, pass_last, row_done, final_pix;
  logic [IDX_W-1:0] nj;

  always_comb begin
    idx       = (NB_W'(byte_in_row_q) >= nbytes) ? last_j : byte_in_row_q;
    end_row   = (idx == last_j);
    rc_inc    = RW_W'(row_count_q) + RW_W'(1);
    glyph_end = end_row && (rc_inc >= rows_eff);
    rep_last  = (rep_q == rep_max);
    bit_last  = (bits_q == gbpe_pkg::BITCNT_W'(1));
    pass_last = (pass_q == rep_max);
    row_done  = (j_q == last_j) && pass_last;
    final_pix = rep_last && bit_last && (!end_row_q || row_done);
    nj        = (j_q == last_j) ? '0 : j_q + IDX_W'(1);
  end

  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.final_pix = final_pix;

  // row position is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_in_row_q <= '0;
      row_count_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        byte_in_row_q <= end_row ? '0 : idx + IDX_W'(1);
        if (end_row) begin
          row_count_q <= glyph_end ? '0 : RC_W'(rc_inc);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and counters, reloaded on every accepted word and stepped on every emitted pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      store_q[idx] <= bitmap_byte_i;
      sh_q         <= bitmap_byte_i;
      bits_q       <= bits_of_byte(width_eff, idx);
      rep_q        <= '0;
      pass_q       <= '0;
      j_q          <= idx;
      end_row_q    <= end_row;
      glyph_end_q  <= glyph_end;
    end else if (cmd_i.emit) begin
      if (!rep_last) begin
        rep_q <= rep_q + REP_W'(1);
      end else begin
        rep_q <= '0;
        if (!bit_last) begin
          sh_q   <= sh_q >> 1;
          bits_q <= bits_q - gbpe_pkg::BITCNT_W'(1);
        end else if (end_row_q && !row_done) begin
          // next stored byte of the row, or the start of a replay pass
          if (j_q == last_j) pass_q <= pass_q + REP_W'(1);
          j_q    <= nj;
          sh_q   <= store_q[nj];
          bits_q <= bits_of_byte(width_eff, nj);
        end
      end
    end
    if (cmd_i.emit) begin
      pixel_q <= sh_q[0] ? pen_color_q : bg_color_q;
      last_q  <= final_pix && glyph_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_color_o   = pixel_q;
  assign last_of_glyph_o = last_q;

endmodule

[rtl/glyph_bitmap_pixel_expander.sv]
// top level of the glyph bitmap pixel expander
// an accepted word is loaded into the shifter; its first pixel goes to the output register once the output slot is free
// throughput: one pixel per cycle while the output slot is free; the word that closes a row
//   also emits the stored row (scale-1) more times for the vertical row replay
// the rate is set by the single output register, which takes one pixel per cycle while the
//   receiver is ready, and between words the sequencer passes through idle to load the next word
// reset: async active low; registers return to defaults, row and glyph position clear
module glyph_bitmap_pixel_expander #(
  parameter int unsigned MAX_GLYPH_WIDTH = gbpe_pkg::MAX_GLYPH_WIDTH_DEF,
  parameter int unsigned MAX_SCALE       = gbpe_pkg::MAX_SCALE_DEF,
  parameter int unsigned MAX_GLYPH_ROWS  = gbpe_pkg::MAX_GLYPH_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // bitmap words in
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gbpe_pkg::BYTE_W-1:0]     bitmap_byte_i,
  // pixel words out
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gbpe_pkg::COLOR_W-1:0]    pixel_color_o,
  output logic                            last_of_glyph_o
);

  // command and status between the sequencer and the datapath
  gbpe_pkg::gbpe_cmd_t cmd;
  gbpe_pkg::gbpe_sts_t sts;

  // sequencer: idle until a word arrives, then pushes one pixel per free output slot
  // and returns to idle on the last pixel of the word (including row replays);
  // the output register lets the next word in while the last pixel waits
  gbpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: config registers, row store, lsb-first shifter, horizontal repeat
  // and vertical replay counters, output register
  gbpe_dpath #(
    .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
    .MAX_SCALE       (MAX_SCALE),
    .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .bitmap_byte_i   (bitmap_byte_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .pixel_color_o   (pixel_color_o),
    .last_of_glyph_o (last_of_glyph_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

[bench/gbpe_pixel_checker.sv]
// pixel word predictor and checker for the glyph bitmap pixel expander
`timescale 1ns / 1ps
module gbpe_pixel_checker
  import gbpe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [BYTE_W-1:0]     bitmap_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [COLOR_W-1:0]    pixel_color_i,
  input  logic                  last_of_glyph_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           words_o,
  output int unsigned           pixels_o,
  output int unsigned           glyph_ends_o
);

  localparam int unsigned MAX_REPORTS = 20;
  localparam int unsigned ROW_BYTES   = 3;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  pixel_t             expected_pixels[$];
  logic [COLOR_W-1:0] pen;
  logic [COLOR_W-1:0] bg;
  logic [WIDTH_W-1:0] glyph_w;
  logic [ROWS_W-1:0]  glyph_rows;
  logic [SCALE_W-1:0] scale;
  logic [BYTE_W-1:0]  row_bytes[ROW_BYTES];
  int unsigned        byte_pos;
  int unsigned        rows_done;
  int unsigned        fails;
  int unsigned        pending;
  int unsigned        words;
  int unsigned        pixels;
  int unsigned        glyph_ends;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign words_o      = words;
  assign pixels_o     = pixels;
  assign glyph_ends_o = glyph_ends;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // pixels that byte number idx of a row still carries
  function automatic int unsigned bits_in_byte(int unsigned width, int unsigned idx);
    if (idx * 8 >= width) return 0;
    return (width - idx * 8 >= 8) ? 8 : width - idx * 8;
  endfunction

  task automatic push_byte_pixels(logic [BYTE_W-1:0] data, int unsigned bits,
                                  int unsigned sc);
    pixel_t px;
    for (int unsigned b = 0; b < bits; b++) begin
      px.color = data[b] ? pen : bg;
      px.last  = 1'b0;
      repeat (sc) expected_pixels.push_back(px);
    end
  endtask

  task automatic expand_word(logic [BYTE_W-1:0] data);
    int unsigned width;
    int unsigned rows;
    int unsigned sc;
    int unsigned nbytes;
    int unsigned idx;
    int unsigned start;
    pixel_t      tail;
    width  = clamp_to(glyph_w, MAX_GLYPH_WIDTH_DEF);
    rows   = clamp_to(glyph_rows, MAX_GLYPH_ROWS_DEF);
    sc     = clamp_to(scale, MAX_SCALE_DEF);
    nbytes = (width + 7) / 8;
    if (nbytes > ROW_BYTES) nbytes = ROW_BYTES;
    start  = expected_pixels.size();
    // a narrower row set mid-row pulls the position back to its last byte
    idx = (byte_pos >= nbytes) ? nbytes - 1 : byte_pos;
    row_bytes[idx] = data;
    push_byte_pixels(data, bits_in_byte(width, idx), sc);
    if (idx + 1 < nbytes) begin
      byte_pos = idx + 1;
      return;
    end
    // vertical scaling replays the stored row
    for (int unsigned rep = 1; rep < sc; rep++) begin
      for (int unsigned j = 0; j < nbytes; j++) begin
        push_byte_pixels(row_bytes[j], bits_in_byte(width, j), sc);
      end
    end
    byte_pos = 0;
    if (rows_done + 1 >= rows) begin
      if (expected_pixels.size() > start) begin
        tail = expected_pixels.pop_back();
        tail.last = 1'b1;
        expected_pixels.push_back(tail);
      end
      rows_done = 0;
    end else begin
      rows_done = (rows_done + 1) % 32;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    logic   bad;
    if (!rst_ni) begin
      pen        = PEN_COLOR_RST;
      bg         = BG_COLOR_RST;
      glyph_w    = GLYPH_W_RST;
      glyph_rows = GLYPH_ROWS_RST;
      scale      = SCALE_RST;
      foreach (row_bytes[i]) row_bytes[i] = '0;
      byte_pos   = 0;
      rows_done  = 0;
      fails      = 0;
      words      = 0;
      pixels     = 0;
      glyph_ends = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PEN_COLOR:  pen        = cfg_data_i[COLOR_W-1:0];
          CFG_BG_COLOR:   bg         = cfg_data_i[COLOR_W-1:0];
          CFG_GLYPH_W:    glyph_w    = cfg_data_i[WIDTH_W-1:0];
          CFG_GLYPH_ROWS: glyph_rows = cfg_data_i[ROWS_W-1:0];
          CFG_SCALE:      scale      = cfg_data_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        words++;
        expand_word(bitmap_byte_i);
      end
      if (out_valid_i && out_ready_i) begin
        pixels++;
        if (last_of_glyph_i === 1'b1) glyph_ends++;
        if (expected_pixels.size() == 0) begin
          if (fails < MAX_REPORTS)
            $display("%0t: pixel word with none expected, got color %h last %b",
                     $time, pixel_color_i, last_of_glyph_i);
          fails++;
        end else begin
          want = expected_pixels.pop_front();
          bad  = 1'b0;
          if (want.color !== pixel_color_i) begin
            bad = 1'b1;
            if (fails < MAX_REPORTS)
              $display("%0t: pixel_color expected %h, got %h",
                       $time, want.color, pixel_color_i);
          end
          if (want.last !== last_of_glyph_i) begin
            bad = 1'b1;
            if (fails < MAX_REPORTS)
              $display("%0t: last_of_glyph expected %b, got %b",
                       $time, want.last, last_of_glyph_i);
          end
          if (bad) fails++;
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

[bench/tb_glyph_bitmap_pixel_expander.sv]
// testbench top: stimulus, flow control and verdict for the glyph bitmap pixel expander
`timescale 1ns / 1ps
module tb_glyph_bitmap_pixel_expander;
  import gbpe_pkg::*;

  // run shape
  localparam int unsigned RANDOM_WORDS = 320;
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 8;     // quiet cycles after the last expected pixel
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  // index that decodes to no register, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {RX_FULL, RX_CHOPPY, RX_SLOW} rx_mode_e;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     bitmap_byte = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  last_flag;

  // set once by the stimulus to start the long hold-off on the pixel side
  logic                  squeeze_req = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_seen;
  int unsigned pixels_seen;
  int unsigned glyph_ends;
  int unsigned burst_left = 0;

  always #5 clk = ~clk;

  glyph_bitmap_pixel_expander dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .bitmap_byte_i   (bitmap_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_color_o   (pixel_color),
    .last_of_glyph_o (last_flag)
  );

  gbpe_pixel_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .bitmap_byte_i   (bitmap_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_color_i   (pixel_color),
    .last_of_glyph_i (last_flag),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_o         (words_seen),
    .pixels_o        (pixels_seen),
    .glyph_ends_o    (glyph_ends)
  );

  // one register write, block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // offer one bitmap word; bursts of random length with random gaps between them
  task automatic push_word(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid    <= 1'b1;
    bitmap_byte <= b;
    // returns at the edge that takes the word
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // stop offering, wait for every expected pixel, then wait out the drain time
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly random content, with all-clear and all-set words mixed in
  function automatic logic [BYTE_W-1:0] random_bitmap_byte();
    logic [BYTE_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // pixel side: runs of full speed, choppy and slow acceptance, plus one long hold-off
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned run_left;
    logic        squeeze_done;
    mode         = RX_FULL;
    run_left     = 0;
    squeeze_done = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        // hold off long enough for the block to back up into its input
        squeeze_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (run_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 2));
        run_left = $urandom_range(4, 40);
      end
      run_left--;
      case (mode)
        RX_FULL:   out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // stimulus
  initial begin : stimulus
    logic [WIDTH_W-1:0] w;
    logic [ROWS_W-1:0]  r;
    logic [SCALE_W-1:0] s;
    logic [15:0]        rnd;
    int unsigned        eff_w;
    int unsigned        eff_rows;
    int unsigned        nbytes;
    int unsigned        n;
    int unsigned        random_sent;
    int unsigned        phases;

    random_sent = 0;
    phases      = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---

    // reset defaults: 8 wide, 8 rows, scale 1, white on black
    push_word(8'h00);
    push_word(8'hFF);
    push_word(8'h01);
    push_word(8'h80);
    settle();

    // zero width, rows and scale act as one; upper data bits must be dropped
    // row count is already past one row, so every row now closes the glyph
    rnd = 16'($urandom);
    write_reg(CFG_PEN_COLOR, rnd);
    rnd = 16'($urandom);
    write_reg(CFG_BG_COLOR, rnd);
    write_reg(CFG_GLYPH_W, 16'hFFE0);
    write_reg(CFG_GLYPH_ROWS, 16'hFFC0);
    write_reg(CFG_SCALE, 16'hFFFC);
    phases++;
    push_word(8'h01);
    push_word(8'hFE);
    settle();

    // all-ones data: width above max, rows above max, scale above max
    write_reg(CFG_PEN_COLOR, 16'h0000);
    write_reg(CFG_BG_COLOR, 16'hFFFF);
    write_reg(CFG_GLYPH_W, 16'hFFFF);
    write_reg(CFG_GLYPH_ROWS, 16'hFFFF);
    write_reg(CFG_SCALE, 16'hFFFF);
    phases++;
    push_word(8'hA5);
    push_word(8'h5A);
    push_word(8'hFF);
    // leave the block two words into the next row
    push_word(8'h80);
    push_word(8'h01);
    settle();

    // narrow row while mid-row: position falls back to the only byte
    write_reg(CFG_GLYPH_W, 16'h0005);
    phases++;
    push_word(8'h1F);
    settle();

    // two-byte rows with replay, then stop after the first byte of a row
    write_reg(CFG_GLYPH_W, 16'h0010);
    phases++;
    push_word(8'h3C);
    push_word(8'hC3);
    push_word(8'h00);
    settle();

    // scale drops mid-row and the row widens to three bytes
    write_reg(CFG_SCALE, 16'h0001);
    write_reg(CFG_GLYPH_W, 16'h0018);
    phases++;
    push_word(8'h81);
    push_word(8'h7E);
    settle();

    // fewer rows than already done: next row closes the glyph
    // a write to the unused index must not touch any register
    write_reg(CFG_GLYPH_ROWS, 16'h0002);
    write_reg(CFG_UNUSED, 16'hFFFF);
    phases++;
    push_word(8'h11);
    push_word(8'h22);
    push_word(8'h33);
    settle();

    // --- random part ---

    // widest rows at double scale while the pixel side holds off
    rnd = 16'($urandom);
    write_reg(CFG_PEN_COLOR, rnd);
    rnd = 16'($urandom);
    write_reg(CFG_BG_COLOR, rnd);
    write_reg(CFG_GLYPH_W, 16'd24);
    write_reg(CFG_GLYPH_ROWS, 16'd4);
    write_reg(CFG_SCALE, 16'd2);
    phases++;
    squeeze_req <= 1'b1;
    for (int unsigned k = 0; k < 24; k++) push_word(random_bitmap_byte());
    random_sent += 24;

    while (random_sent < RANDOM_WORDS) begin
      settle();
      // mostly legal settings, sometimes out of range ones
      case ($urandom_range(0, 9))
        0:       w = 5'd0;
        1:       w = 5'($urandom_range(25, 31));
        default: w = 5'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 11))
        0:       r = 6'd0;
        1:       r = 6'($urandom_range(33, 63));
        2:       r = 6'd32;
        3, 4:    r = 6'($urandom_range(7, 31));
        default: r = 6'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       s = 2'd0;
        1:       s = 2'd3;
        default: s = 2'($urandom_range(1, 2));
      endcase
      eff_w    = (w == 0) ? 1 : ((w > 24) ? 24 : w);
      eff_rows = (r == 0) ? 1 : ((r > 32) ? 32 : r);
      nbytes   = (eff_w + 7) / 8;

      rnd = 16'($urandom);
      write_reg(CFG_PEN_COLOR, rnd);
      rnd = 16'($urandom);
      write_reg(CFG_BG_COLOR, rnd);
      rnd = 16'($urandom);
      write_reg(CFG_GLYPH_W, {rnd[15:5], w});
      rnd = 16'($urandom);
      write_reg(CFG_GLYPH_ROWS, {rnd[15:6], r});
      rnd = 16'($urandom);
      write_reg(CFG_SCALE, {rnd[15:2], s});
      phases++;

      // whole glyphs, sometimes with a partial one left open for the next setting
      n = nbytes * eff_rows * ((eff_rows > 8) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 5);
      for (int unsigned k = 0; k < n; k++) push_word(random_bitmap_byte());
      random_sent += n;
    end

    settle();

    $display("run: %0d bitmap words over %0d register settings, incl. scale and size limits",
             words_seen, phases);
    $display("run: %0d pixel words checked, %0d glyph ends seen, %0d failures",
             pixels_seen, glyph_ends, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_glyph_bitmap_pixel_expander: PASS");
    end else begin
      $display("tb_glyph_bitmap_pixel_expander: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: run did not finish in time, %0d pixel words still expected",
             $time, pending);
    $display("tb_glyph_bitmap_pixel_expander: FAIL");
    $finish;
  end

endmodule
